>>> design/cbce_pkg.sv
package cbce_pkg;

  localparam int MAX_POINTS_DEF = 12;
  localparam int MAX_KNOTS_DEF  = 16;

  localparam logic signed [31:0] Q_ONE = 32'sd65536;
  localparam logic [3:0] POINT_COUNT_RST = 4'd4;

  localparam logic [1:0] FUNC_KNOT  = 2'd0;
  localparam logic [1:0] FUNC_POINT = 2'd1;
  localparam logic [1:0] FUNC_EVAL  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_DOMAIN   = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

>>> design/cubic_bspline_curve_evaluator.sv
// Cubic B-spline curve evaluator in Q16.16. Knots and control points are loaded
// by input transactions, and an evaluate transaction returns the curve point at
// parameter u. The block takes one item at a time. A load goes from idle
// straight to the output stage. An evaluation scans knots 3..n, then runs
// 15 Cox-de Boor steps of two recurrence terms each on one shared 32x32
// multiplier and one bit-serial divider: a term is divided only when its
// product and denominator are nonzero, and each step first reads its four
// knots. Each of the three degree passes ends by realigning the weight
// registers. The final weighted sum reads four points and runs 12
// multiply-accumulate passes. An output stall holds the block in its output
// stage; the result register lets the next item in while a result waits.
module cubic_bspline_curve_evaluator
  import cbce_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int MAX_KNOTS  = MAX_KNOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] curve_x,
  output logic signed [31:0] curve_y,
  output logic signed [31:0] curve_z,
  output logic [1:0]         status,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);

  localparam int KAW = $clog2(MAX_KNOTS);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int NW  = $clog2(MAX_KNOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SPAN, S_STEP, S_KRD, S_MUL, S_DIV0, S_DIV,
    S_TDONE, S_ADV, S_PRD, S_WMUL, S_WACC, S_FIN, S_OUT
  } state_t;

  state_t state;
  logic [3:0] point_count;
  logic [NW-1:0] nn;
  logic [NW-1:0] kidx, kd, span, span1, span2, ibase, rec_addr;
  logic first, f1, f2, rside;
  logic signed [31:0] u, prev, t3, tn, ka, kb, kc, kdd;
  logic signed [31:0] opa, opb, den, lval;
  logic signed [31:0] b [7];
  logic [1:0] d, c;
  logic [2:0] o, ph;
  logic signed [63:0] prod, prod_full, wadj;
  logic signed [31:0] mul_a, mul_b, wval, tval;
  logic [62:0] dvd;
  logic [31:0] dvs, rem;
  logic [32:0] rem_sh;
  logic [5:0] cnt;
  logic neg;
  logic signed [34:0] accx, accy, accz;
  logic signed [31:0] res_x, res_y, res_z;
  logic [1:0] res_st;
  logic signed [31:0] pcoord;

  logic knot_we, point_we;
  logic [KAW-1:0] knot_raddr;
  logic [31:0] kq;
  logic [95:0] pq;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    int v;
    v = int'(point_count);
    if (v < 4) v = 4;
    if (v > MAX_POINTS) v = MAX_POINTS;
    if (v + 4 > MAX_KNOTS) v = MAX_KNOTS - 4;
    nn = NW'(v);
  end

  assign knot_we  = in_valid && in_ready && func == FUNC_KNOT && 32'(slot) < MAX_KNOTS;
  assign point_we = in_valid && in_ready && func == FUNC_POINT && 32'(slot) < MAX_POINTS;

  assign kd    = kidx - NW'(1);
  assign ibase = span - NW'(3) + NW'(o);

  always_comb begin
    case (ph)
      3'd0: rec_addr = ibase;
      3'd1: rec_addr = ibase + NW'(d);
      3'd2: rec_addr = ibase + NW'(1);
      3'd3: rec_addr = ibase + NW'(d) + NW'(1);
      default: rec_addr = ibase;
    endcase
  end

  assign knot_raddr = (state == S_SCAN) ? KAW'(kidx) : KAW'(rec_addr);

  cbce_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_knot_ram (
    .clk(clk), .we(knot_we), .waddr(KAW'(slot)), .wdata(coord_x),
    .raddr(knot_raddr), .rdata(kq)
  );

  cbce_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(point_we), .waddr(PAW'(slot)), .wdata({coord_z, coord_y, coord_x}),
    .raddr(PAW'(ibase)), .rdata(pq)
  );

  always_comb begin
    case (c)
      2'd0: pcoord = pq[31:0];
      2'd1: pcoord = pq[63:32];
      default: pcoord = pq[95:64];
    endcase
  end

  assign mul_a     = (state == S_WMUL) ? b[0] : opa;
  assign mul_b     = (state == S_WMUL) ? pcoord : opb;
  assign prod_full = 64'(mul_a) * 64'(mul_b);

  assign rem_sh = {rem, dvd[62]};
  assign tval   = sat32(neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd}));
  assign wadj   = (prod < 0) ? prod + 64'sd65535 : prod;
  assign wval   = sat32(wadj >>> 16);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= POINT_COUNT_RST;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) point_count <= cfg_data;
      if (out_ready && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_x  <= '0;
            res_y  <= '0;
            res_z  <= '0;
            case (func)
              FUNC_KNOT: begin
                res_st <= (32'(slot) >= MAX_KNOTS) ? ST_BAD_SLOT : ST_OK;
                state  <= S_OUT;
              end
              FUNC_POINT: begin
                res_st <= (32'(slot) >= MAX_POINTS) ? ST_BAD_SLOT : ST_OK;
                state  <= S_OUT;
              end
              FUNC_EVAL: begin
                res_st <= ST_OK;
                u      <= coord_x;
                kidx   <= NW'(3);
                first  <= 1'b1;
                f1     <= 1'b0;
                f2     <= 1'b0;
                state  <= S_SCAN;
              end
              default: begin
                res_st <= ST_OK;
                state  <= S_OUT;
              end
            endcase
          end
        end
        S_SCAN: begin
          first <= 1'b0;
          if (first) begin
            kidx <= kidx + NW'(1);
          end else begin
            if (kd == NW'(3)) t3 <= kq;
            if (kd == nn) tn <= kq;
            if (kd > NW'(3)) begin
              if (!f1 && prev <= u && u < $signed(kq)) begin
                span1 <= kd - NW'(1);
                f1    <= 1'b1;
              end
              if (prev < $signed(kq)) begin
                span2 <= kd - NW'(1);
                f2    <= 1'b1;
              end
            end
            prev <= kq;
            if (kd == nn) state <= S_SPAN;
            else kidx <= kidx + NW'(1);
          end
        end
        S_SPAN: begin
          if (u < t3 || u > tn || !(f1 || (u == tn && f2))) begin
            res_st <= ST_DOMAIN;
            state  <= S_OUT;
          end else begin
            span <= f1 ? span1 : span2;
            for (int k = 0; k < 7; k++) b[k] <= (k == 3) ? Q_ONE : '0;
            d     <= 2'd1;
            o     <= 3'd0;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (o < 3'd7 - {1'b0, d}) begin
            ph    <= 3'd0;
            state <= S_KRD;
          end else begin
            for (int k = 0; k < 6; k++) b[k] <= b[k+1];
            b[6]  <= b[0];
            state <= S_ADV;
          end
        end
        S_KRD: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd1: ka <= kq;
            3'd2: kb <= kq;
            3'd3: kc <= kq;
            3'd4: begin
              kdd   <= kq;
              opa   <= sat32(64'(u) - 64'(ka));
              den   <= sat32(64'(kb) - 64'(ka));
              opb   <= b[0];
              rside <= 1'b0;
              state <= S_MUL;
            end
            default: ;
          endcase
        end
        S_MUL: begin
          prod  <= prod_full;
          state <= S_DIV0;
        end
        S_DIV0: begin
          if (den == 0 || prod == 0) begin
            dvd   <= '0;
            neg   <= 1'b0;
            state <= S_TDONE;
          end else begin
            dvd   <= (prod < 0) ? 63'(-prod) : prod[62:0];
            dvs   <= (den < 0) ? 32'(-64'(den)) : den;
            neg   <= prod[63] ^ den[31];
            rem   <= '0;
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem <= 32'(rem_sh - {1'b0, dvs});
            dvd <= {dvd[61:0], 1'b1};
          end else begin
            rem <= rem_sh[31:0];
            dvd <= {dvd[61:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd62) state <= S_TDONE;
        end
        S_TDONE: begin
          if (!rside) begin
            lval  <= tval;
            opa   <= sat32(64'(kdd) - 64'(u));
            den   <= sat32(64'(kdd) - 64'(kc));
            opb   <= b[1];
            rside <= 1'b1;
            state <= S_MUL;
          end else begin
            for (int k = 0; k < 6; k++) b[k] <= b[k+1];
            b[6]  <= sat32(64'(lval) + 64'(tval));
            state <= S_ADV;
          end
        end
        S_ADV: begin
          if (o == 3'd6) begin
            o <= 3'd0;
            if (d == 2'd3) begin
              c     <= 2'd0;
              accx  <= '0;
              accy  <= '0;
              accz  <= '0;
              state <= S_PRD;
            end else begin
              d     <= d + 2'd1;
              state <= S_STEP;
            end
          end else begin
            o     <= o + 3'd1;
            state <= S_STEP;
          end
        end
        S_PRD: state <= S_WMUL;
        S_WMUL: begin
          prod  <= prod_full;
          state <= S_WACC;
        end
        S_WACC: begin
          case (c)
            2'd0: accx <= accx + 35'(wval);
            2'd1: accy <= accy + 35'(wval);
            default: accz <= accz + 35'(wval);
          endcase
          if (c == 2'd2) begin
            c <= 2'd0;
            for (int k = 0; k < 6; k++) b[k] <= b[k+1];
            b[6] <= b[0];
            if (o == 3'd3) begin
              state <= S_FIN;
            end else begin
              o     <= o + 3'd1;
              state <= S_PRD;
            end
          end else begin
            c     <= c + 2'd1;
            state <= S_WMUL;
          end
        end
        S_FIN: begin
          res_x <= sat32(64'(accx));
          res_y <= sat32(64'(accy));
          res_z <= sat32(64'(accz));
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            curve_x   <= res_x;
            curve_y   <= res_y;
            curve_z   <= res_z;
            status    <= res_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> design/cbce_ram.sv
module cbce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

>>> tb/sv/cubic_bspline_curve_evaluator_checker.sv
`timescale 1ns / 1ps

module cubic_bspline_curve_evaluator_checker
  import cbce_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         func,
  input  logic [3:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] curve_x,
  input  logic signed [31:0] curve_y,
  input  logic signed [31:0] curve_z,
  input  logic [1:0]         status,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output int                 fail_count,
  output int                 pending,
  output int                 curve_points_ok,
  output int                 results_seen
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [1:0]         st;
  } curve_res_t;

  curve_res_t expected_curve_q[$];
  longint     knot_tab[16];
  longint     pnt_x[12];
  longint     pnt_y[12];
  longint     pnt_z[12];
  logic [3:0] count_reg;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint blend_term(longint a, longint b, longint c, longint d,
                                        longint nv);
    longint diff;
    longint den;
    diff = clip32(a - b);
    den = clip32(c - d);
    if (den == 0) return 0;
    return clip32((diff * nv) / den);
  endfunction

  function automatic curve_res_t eval_curve(longint u);
    curve_res_t r;
    int n;
    int span;
    bit found;
    longint w[7];
    longint sx;
    longint sy;
    longint sz;
    longint lt;
    longint rt;
    int i;
    r = '{0, 0, 0, ST_OK};
    n = int'(count_reg);
    if (n < 4) n = 4;
    if (n > 12) n = 12;
    if (n + 4 > 16) n = 12;
    span = 0;
    found = 0;
    if (u < knot_tab[3] || u > knot_tab[n]) begin
      r.st = ST_DOMAIN;
      return r;
    end
    for (int j = 3; j < n && !found; j++) begin
      if (knot_tab[j] <= u && u < knot_tab[j+1]) begin
        span = j;
        found = 1;
      end
    end
    if (!found && u == knot_tab[n]) begin
      for (int j = 3; j < n; j++) begin
        if (knot_tab[j] < knot_tab[j+1]) begin
          span = j;
          found = 1;
        end
      end
    end
    if (!found) begin
      r.st = ST_DOMAIN;
      return r;
    end
    for (int o = 0; o < 7; o++) w[o] = 0;
    w[3] = 65536;
    for (int d = 1; d <= 3; d++) begin
      for (int o = 0; o + d < 7; o++) begin
        i = span - 3 + o;
        lt = blend_term(u, knot_tab[i], knot_tab[i+d], knot_tab[i], w[o]);
        rt = blend_term(knot_tab[i+d+1], u, knot_tab[i+d+1], knot_tab[i+1], w[o+1]);
        w[o] = clip32(lt + rt);
      end
    end
    sx = 0;
    sy = 0;
    sz = 0;
    for (int o = 0; o < 4; o++) begin
      sx += clip32((w[o] * pnt_x[span-3+o]) / 65536);
      sy += clip32((w[o] * pnt_y[span-3+o]) / 65536);
      sz += clip32((w[o] * pnt_z[span-3+o]) / 65536);
    end
    r.x = 32'(clip32(sx));
    r.y = 32'(clip32(sy));
    r.z = 32'(clip32(sz));
    return r;
  endfunction

  always @(posedge clk) begin
    curve_res_t e;
    curve_res_t got;
    if (rst) begin
      count_reg = POINT_COUNT_RST;
      expected_curve_q.delete();
      fail_count = 0;
      curve_points_ok = 0;
      results_seen = 0;
      for (int k = 0; k < 16; k++) knot_tab[k] = 0;
      for (int k = 0; k < 12; k++) begin
        pnt_x[k] = 0;
        pnt_y[k] = 0;
        pnt_z[k] = 0;
      end
    end else begin
      if (cfg_valid && cfg_ready) count_reg = cfg_data;
      if (in_valid && in_ready) begin
        e = '{0, 0, 0, ST_OK};
        if (func == FUNC_KNOT) begin
          knot_tab[slot] = coord_x;
        end else if (func == FUNC_POINT) begin
          if (slot < 12) begin
            pnt_x[slot] = coord_x;
            pnt_y[slot] = coord_y;
            pnt_z[slot] = coord_z;
          end else begin
            e.st = ST_BAD_SLOT;
          end
        end else if (func == FUNC_EVAL) begin
          e = eval_curve(coord_x);
        end
        expected_curve_q = {expected_curve_q, e};
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got = '{curve_x, curve_y, curve_z, status};
        if (expected_curve_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result transaction st=%0d", status);
        end else begin
          e = expected_curve_q.pop_front();
          if (got != e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch exp x=%h y=%h z=%h st=%0d got x=%h y=%h z=%h st=%0d",
                       e.x, e.y, e.z, e.st, got.x, got.y, got.z, got.st);
          end else if (e.st == ST_OK && (e.x != 0 || e.y != 0 || e.z != 0)) begin
            curve_points_ok++;
          end
        end
      end
    end
    pending = expected_curve_q.size();
  end

endmodule

>>> tb/sv/cubic_bspline_curve_evaluator_test.sv
`timescale 1ns / 1ps

module cubic_bspline_curve_evaluator_test
  import cbce_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 60000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         func = FUNC_KNOT;
  logic [3:0]         slot = 0;
  logic signed [31:0] coord_x = 0;
  logic signed [31:0] coord_y = 0;
  logic signed [31:0] coord_z = 0;
  logic               out_valid;
  logic               out_ready = 1;
  logic signed [31:0] curve_x;
  logic signed [31:0] curve_y;
  logic signed [31:0] curve_z;
  logic [1:0]         status;
  logic               cfg_valid = 0;
  logic               cfg_ready;
  logic [3:0]         cfg_data = 0;

  int     fail_count;
  int     pending;
  int     curve_points_ok;
  int     results_seen;
  bit     calm = 0;
  bit     gaps_on = 0;
  int     stall_left = 0;
  int     quiet_cycles = 0;
  int     settings_used = 0;
  int     n_use = 4;
  longint knot_copy[16];

  always #4 clk = ~clk;

  cubic_bspline_curve_evaluator u_top (.*);

  cubic_bspline_curve_evaluator_checker u_check (.*);

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 0;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic [1:0] f, logic [3:0] s, logic signed [31:0] x,
                      logic signed [31:0] y, logic signed [31:0] z);
    int gap;
    @(negedge clk);
    if (gaps_on && !calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    func <= f;
    slot <= s;
    coord_x <= x;
    coord_y <= y;
    coord_z <= z;
    if (f == FUNC_KNOT) knot_copy[s] = x;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 0;
    wait (pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_count(logic [3:0] v);
    drain();
    cfg_valid <= 1;
    cfg_data <= v;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 0;
    n_use = (v < 4) ? 4 : (v > 12) ? 12 : int'(v);
    settings_used++;
  endtask

  function automatic logic signed [31:0] any_word();
    return $urandom();
  endfunction

  task automatic load_knots(int style);
    longint k;
    k = $signed($urandom_range(0, 2 ** 21)) - 2 ** 20;
    for (int i = 0; i < 16; i++) begin
      send(FUNC_KNOT, 4'(i), 32'(k), any_word(), any_word());
      case (style)
        0: k += $urandom_range(0, 2) * 65536;
        1: k += $urandom_range(0, 3) * 65536 + $urandom_range(0, 65535);
        default: k += $urandom_range(0, 2 ** 26);
      endcase
    end
  endtask

  task automatic load_points(bit wide);
    for (int i = 0; i < 12; i++) begin
      if (wide)
        send(FUNC_POINT, 4'(i), any_word(), any_word(), any_word());
      else
        send(FUNC_POINT, 4'(i), $signed($urandom_range(0, 2 ** 25)) - 2 ** 24,
             $signed($urandom_range(0, 2 ** 25)) - 2 ** 24,
             $signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
    end
  endtask

  function automatic logic signed [31:0] inside_u();
    longint lo;
    longint w;
    lo = knot_copy[3];
    w = knot_copy[n_use] - lo;
    if (w < 0) return 32'(lo);
    if ($urandom_range(0, 5) == 0) return 32'(knot_copy[$urandom_range(3, n_use)]);
    return 32'(lo + ({32'd0, $urandom()} % (w + 1)));
  endfunction

  task automatic random_item();
    int pick;
    longint v;
    int s;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      send(FUNC_EVAL, 4'($urandom()), inside_u(), any_word(), any_word());
    end else if (pick < 28) begin
      send(FUNC_EVAL, 4'($urandom()), any_word(), any_word(), any_word());
    end else if (pick < 68) begin
      if ($urandom_range(0, 4) == 0)
        send(FUNC_POINT, 4'($urandom()), any_word(), any_word(), any_word());
      else
        send(FUNC_POINT, 4'($urandom_range(0, 11)),
             $signed($urandom_range(0, 2 ** 23)) - 2 ** 22,
             $signed($urandom_range(0, 2 ** 23)) - 2 ** 22, any_word());
    end else if (pick < 90) begin
      s = $urandom_range(0, 15);
      v = knot_copy[s] + $signed($urandom_range(0, 131072)) - 65536;
      if (v > 64'sd2147483647 || v < -64'sd2147483648) v = knot_copy[s];
      send(FUNC_KNOT, 4'(s), 32'(v), any_word(), any_word());
    end else if (pick < 93) begin
      send(FUNC_KNOT, 4'($urandom()), any_word(), any_word(), any_word());
    end else begin
      send(FUNC_UNUSED, 4'($urandom()), any_word(), any_word(), any_word());
    end
  endtask

  initial begin
    logic [3:0] plan[8];
    plan = '{4'd12, 4'd4, 4'd0, 4'd15, 4'd7, 4'd12, 4'd9, 4'd4};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // repeated knots give zero denominators
    load_knots(0);
    load_points(0);
    send(FUNC_POINT, 4'd0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(FUNC_POINT, 4'd1, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send(FUNC_POINT, 4'd2, 32'sh7fffffff, 32'sh80000000, 32'sd0);
    send(FUNC_POINT, 4'd3, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send(FUNC_EVAL, 4'd0, 32'(knot_copy[3]), 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, 32'(knot_copy[4]), 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, 32'(knot_copy[3] - 1), 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, 32'(knot_copy[4] + 1), 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, 32'sh80000000, 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, 32'sh7fffffff, 32'sd0, 32'sd0);
    send(FUNC_EVAL, 4'd0, inside_u(), 32'sd0, 32'sd0);
    send(FUNC_POINT, 4'd12, 32'sd1, 32'sd2, 32'sd3);
    send(FUNC_POINT, 4'd15, -32'sd1, -32'sd1, -32'sd1);
    send(FUNC_KNOT, 4'd15, 32'(knot_copy[15]), 32'sd0, 32'sd0);
    send(FUNC_UNUSED, 4'hf, -32'sd1, -32'sd1, -32'sd1);
    send(FUNC_EVAL, 4'hf, inside_u(), 32'sd0, 32'sd0);

    gaps_on = 1;
    for (int ph = 0; ph < 8; ph++) begin
      set_count(plan[ph]);
      if (ph == 7) calm = 1;
      load_knots(ph % 3);
      load_points(ph == 3);
      for (int i = 0; i < 150; i++) begin
        if (ph == 4 && i == 75) drain();
        random_item();
      end
    end

    @(negedge clk);
    in_valid <= 0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    $display("checked %0d result transactions, %0d nonzero curve points, %0d count settings",
             results_seen, curve_points_ok, settings_used);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> cubic_bspline_curve_evaluator.f
design/cbce_pkg.sv
design/cbce_ram.sv
design/cubic_bspline_curve_evaluator.sv
tb/sv/cubic_bspline_curve_evaluator_checker.sv
tb/sv/cubic_bspline_curve_evaluator_test.sv
